[hw/rtl/lmrs_pkg.sv]
// Shared types and constants for the LED matrix row scanner.
// Used by the request and configuration interfaces, the frame store and the top level.
package lmrs_pkg;

   // Frame store geometry: 4096 pixels of six color bits each
   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PIX_W       = 6;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 32;
   localparam int DEF_FLUSH_TICKS = 8;

   // Row address lines on the panel
   localparam int ROW_W      = 5;
   localparam int ROW_BITS_MAX = 5;

   // Widths of the configuration fields
   localparam int CSR_DATA_W = 20;
   localparam int WAIT_W     = 20;

   // Register reset values
   localparam logic [7:0]  RST_COLUMNS      = 8'd64;
   localparam logic [5:0]  RST_ROWS_SCANNED = 6'd16;
   localparam logic [2:0]  RST_ROW_BITS     = 3'd4;
   localparam logic [4:0]  RST_DATA_SHIFT   = 5'd0;
   localparam logic [19:0] RST_ON_TICKS     = 20'd0;
   localparam logic [7:0]  RST_SETUP_TICKS  = 8'd2;
   localparam logic [7:0]  RST_HALF_PERIOD  = 8'd6;
   localparam logic [7:0]  RST_LATCH_TICKS  = 8'd6;

   // Item function codes
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_SWAP  = 2'd2,
      FUNC_START = 2'd3
   } func_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_COLUMNS      = 3'd0,
      CSR_ROWS_SCANNED = 3'd1,
      CSR_ROW_BITS     = 3'd2,
      CSR_DATA_SHIFT   = 3'd3,
      CSR_ON_TICKS     = 3'd4,
      CSR_SETUP_TICKS  = 3'd5,
      CSR_HALF_PERIOD  = 3'd6,
      CSR_LATCH_TICKS  = 3'd7
   } csr_index_type;

   // Write request into one frame store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  data;
   } store_wr_type;

endpackage

[hw/rtl/lmrs_req_if.sv]
// Request channel of the LED matrix row scanner: valid/ready plus one item.
// Depends on lmrs_pkg for the function code type.
interface lmrs_req_if import lmrs_pkg::*; ;
   logic        valid;
   logic        ready;
   func_type    func;
   logic [11:0] pixel_index;
   logic [31:0] gpio_word;
   logic [15:0] frame_count;

   modport source (output valid, func, pixel_index, gpio_word, frame_count, input ready);
   modport sink   (input valid, func, pixel_index, gpio_word, frame_count, output ready);
endinterface

[hw/rtl/lmrs_rsp_if.sv]
// Response channel of the LED matrix row scanner: valid/ready plus pin levels.
// Standalone; no package items needed.
interface lmrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] rgb;
   logic       shift_clock;
   logic       latch;
   logic       blank;
   logic [4:0] row_address;
   logic       busy_res;
   logic       frame_done;

   modport source (output valid, rgb, shift_clock, latch, blank, row_address, busy_res,
                   frame_done, input ready);
   modport sink   (input valid, rgb, shift_clock, latch, blank, row_address, busy_res,
                   frame_done, output ready);
endinterface

[hw/rtl/lmrs_csr_if.sv]
// Configuration write channel of the LED matrix row scanner.
// Depends on lmrs_pkg for the register index type and data width.
interface lmrs_csr_if import lmrs_pkg::*; ;
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/lmrs_frame_store.sv]
// One 4096 x 6 frame store: one write port, one read port with registered data.
// Depends on lmrs_pkg for geometry and the write request struct.
module lmrs_frame_store import lmrs_pkg::*; (
   input  logic               clock,
   input  store_wr_type       wr,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [PIX_W-1:0]   rd_data
);

   logic [PIX_W-1:0] mem_ff [STORE_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/led_matrix_row_scanner.sv]
// Row scanner for a two-half RGB LED panel. Each accepted item returns one result holding
// the panel pin levels after that item; a tick item advances panel timing by one step, so
// the block takes one item per cycle when the result side does not stall it, its result
// registered in the cycle after, and the output register is the state itself. After reset
// the two 4096-pixel frame stores are cleared in one pass, one address per cycle in both
// stores at once; no item is accepted during that pass, configuration writes are. Pixel reads
// go through the synchronous read port of the front store and reach the result in the same cycle as the rest.
module led_matrix_row_scanner import lmrs_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int FLUSH_TICKS = DEF_FLUSH_TICKS
) (
   input  logic        clock,
   input  logic        reset,
   lmrs_req_if.sink    req_if,
   lmrs_rsp_if.source  rsp_if,
   lmrs_csr_if.sink    csr_if
);

   localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
   localparam int CNT_W  = $clog2(MAX_COLUMNS);
   localparam int CMP_W  = (COL_W > 8) ? COL_W : 8;
   localparam int PROD_W = ROW_W + CMP_W;

   typedef enum logic [2:0] {
      PH_IDLE, PH_SETUP, PH_LOW, PH_HIGH, PH_FLUSH, PH_LATCH, PH_ON
   } phase_type;

   // configuration registers
   logic [7:0]        columns_ff;
   logic [5:0]        rows_scanned_ff;
   logic [2:0]        row_bits_ff;
   logic [4:0]        data_shift_ff;
   logic [WAIT_W-1:0] on_ticks_ff;
   logic [7:0]        setup_ticks_ff;
   logic [7:0]        half_period_ff;
   logic [7:0]        latch_ticks_ff;

   // scan state and pin levels
   phase_type         phase_ff, phase_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [15:0]       frames_ff, frames_in;
   logic              front_ff, front_in;
   logic              swap_ff, swap_in;
   logic              clk_ff, clk_in;
   logic              lat_ff, lat_in;
   logic              blank_ff, blank_in;
   logic [ROW_W-1:0]  addr_ff, addr_in;
   logic              done_ff, done_in;
   logic [PIX_W-1:0]  rgb_ff;
   logic              rgb_sel_ff;
   logic              rd_front_ff;
   logic              rsp_valid_ff;

   // clearing pass
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // datapath
   logic              req_fire;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [PIX_W-1:0]  rd_data_a, rd_data_b;
   logic [PIX_W-1:0]  rgb_shown;
   logic [PIX_W-1:0]  wr_pixel;
   store_wr_type      wr_a, wr_b;

   logic [CMP_W-1:0]  eff_cols;
   logic [5:0]        eff_rows;
   logic [2:0]        eff_row_bits;
   logic [ROW_W-1:0]  addr_keep;
   logic [WAIT_W-1:0] half_ticks;
   logic [31:0]       shifted_word;

   // handshakes
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_if.ready = !clearing_ff && (!rsp_valid_ff || rsp_if.ready);
   assign csr_if.ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff      <= RST_COLUMNS;
         rows_scanned_ff <= RST_ROWS_SCANNED;
         row_bits_ff     <= RST_ROW_BITS;
         data_shift_ff   <= RST_DATA_SHIFT;
         on_ticks_ff     <= RST_ON_TICKS;
         setup_ticks_ff  <= RST_SETUP_TICKS;
         half_period_ff  <= RST_HALF_PERIOD;
         latch_ticks_ff  <= RST_LATCH_TICKS;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_COLUMNS:      columns_ff      <= csr_if.data[7:0];
            CSR_ROWS_SCANNED: rows_scanned_ff <= csr_if.data[5:0];
            CSR_ROW_BITS:     row_bits_ff     <= csr_if.data[2:0];
            CSR_DATA_SHIFT:   data_shift_ff   <= csr_if.data[4:0];
            CSR_ON_TICKS:     on_ticks_ff     <= csr_if.data[WAIT_W-1:0];
            CSR_SETUP_TICKS:  setup_ticks_ff  <= csr_if.data[7:0];
            CSR_HALF_PERIOD:  half_period_ff  <= csr_if.data[7:0];
            CSR_LATCH_TICKS:  latch_ticks_ff  <= csr_if.data[7:0];
            default: ;
         endcase
      end
   end

   // saturated views of the registers
   always_comb begin
      eff_cols = CMP_W'(columns_ff);
      if (eff_cols == '0) begin
         eff_cols = CMP_W'(1);
      end else if (eff_cols > CMP_W'(MAX_COLUMNS)) begin
         eff_cols = CMP_W'(MAX_COLUMNS);
      end
      eff_rows = rows_scanned_ff;
      if (eff_rows == '0) begin
         eff_rows = 6'd1;
      end else if (eff_rows > 6'(MAX_ROWS)) begin
         eff_rows = 6'(MAX_ROWS);
      end
      eff_row_bits = row_bits_ff;
      if (eff_row_bits == '0) begin
         eff_row_bits = 3'd1;
      end else if (eff_row_bits > 3'(ROW_BITS_MAX)) begin
         eff_row_bits = 3'(ROW_BITS_MAX);
      end
      addr_keep  = ROW_W'((6'd1 << eff_row_bits) - 6'd1);
      half_ticks = (half_period_ff == '0) ? WAIT_W'(1) : WAIT_W'(half_period_ff);
   end

   // next scan state: one tick, with zero-length phases passed through in the same cycle
   always_comb begin
      logic              go_setup, go_low, go_high, go_flush, go_latch, go_on, go_rowend;
      logic [PROD_W-1:0] pix_full;

      phase_in  = phase_ff;
      wait_in   = wait_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      frames_in = frames_ff;
      front_in  = front_ff;
      swap_in   = swap_ff;
      clk_in    = clk_ff;
      lat_in    = lat_ff;
      blank_in  = blank_ff;
      addr_in   = addr_ff;
      done_in   = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      go_setup  = 1'b0;
      go_low    = 1'b0;
      go_high   = 1'b0;
      go_flush  = 1'b0;
      go_latch  = 1'b0;
      go_on     = 1'b0;
      go_rowend = 1'b0;
      pix_full  = '0;

      case (req_if.func)
         FUNC_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (wait_ff > WAIT_W'(1)) begin
                  wait_in = wait_ff - WAIT_W'(1);
               end else begin
                  wait_in = '0;
                  case (phase_ff)
                     PH_SETUP: go_low   = 1'b1;
                     PH_LOW:   go_high  = 1'b1;
                     PH_HIGH: begin
                        if (CMP_W'(col_ff) + CMP_W'(1) >= eff_cols) begin
                           go_flush = 1'b1;
                        end else begin
                           col_in = col_ff + CNT_W'(1);
                           go_low = 1'b1;
                        end
                     end
                     PH_FLUSH: go_latch  = 1'b1;
                     PH_LATCH: go_on     = 1'b1;
                     default:  go_rowend = 1'b1;
                  endcase
               end
            end
         end
         FUNC_SWAP: begin
            if (phase_ff != PH_IDLE) begin
               swap_in = !swap_ff;
            end else begin
               front_in = !front_ff;
            end
         end
         FUNC_START: begin
            if (phase_ff == PH_IDLE && req_if.frame_count != '0) begin
               frames_in = req_if.frame_count;
               row_in    = '0;
               col_in    = '0;
               go_setup  = 1'b1;
            end
         end
         default: ;
      endcase

      // shift clock parked low, then flush
      if (go_flush) begin
         clk_in = 1'b0;
         if (FLUSH_TICKS == 0) begin
            go_latch = 1'b1;
         end else begin
            phase_in = PH_FLUSH;
            wait_in  = WAIT_W'(FLUSH_TICKS);
         end
      end

      // latch pulse
      if (go_latch) begin
         lat_in = 1'b1;
         if (latch_ticks_ff == '0) begin
            go_on = 1'b1;
         end else begin
            phase_in = PH_LATCH;
            wait_in  = WAIT_W'(latch_ticks_ff);
         end
      end

      // row lit
      if (go_on) begin
         lat_in   = 1'b0;
         blank_in = 1'b0;
         if (on_ticks_ff == '0) begin
            go_rowend = 1'b1;
         end else begin
            phase_in = PH_ON;
            wait_in  = on_ticks_ff;
         end
      end

      // next row or end of frame
      if (go_rowend) begin
         col_in = '0;
         if (6'(row_ff) + 6'd1 >= eff_rows) begin
            blank_in = 1'b1;
            lat_in   = 1'b0;
            clk_in   = 1'b0;
            done_in  = 1'b1;
            if (frames_ff != '0) begin
               frames_in = frames_ff - 16'd1;
            end
            if (swap_ff) begin
               front_in = !front_ff;
               swap_in  = 1'b0;
            end
            row_in = '0;
            if (frames_in == '0) begin
               phase_in = PH_IDLE;
               wait_in  = '0;
            end else begin
               go_setup = 1'b1;
            end
         end else begin
            row_in   = row_ff + ROW_W'(1);
            go_setup = 1'b1;
         end
      end

      // row address setup with the panel dark
      if (go_setup) begin
         blank_in = 1'b1;
         lat_in   = 1'b0;
         clk_in   = 1'b0;
         addr_in  = row_in & addr_keep;
         if (setup_ticks_ff == '0) begin
            go_low = 1'b1;
         end else begin
            phase_in = PH_SETUP;
            wait_in  = WAIT_W'(setup_ticks_ff);
         end
      end

      // pixel out, clock low; color comes from the front store read
      if (go_low) begin
         pix_full = PROD_W'(row_in) * PROD_W'(eff_cols) + PROD_W'(col_in);
         rd_en    = 1'b1;
         rd_addr  = pix_full[ADDR_W-1:0];
         clk_in   = 1'b0;
         phase_in = PH_LOW;
         wait_in  = half_ticks;
      end

      // clock high
      if (go_high) begin
         clk_in   = 1'b1;
         phase_in = PH_HIGH;
         wait_in  = half_ticks;
      end
   end

   // scan state, pin levels and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         wait_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         frames_ff    <= '0;
         front_ff     <= 1'b0;
         swap_ff      <= 1'b0;
         clk_ff       <= 1'b0;
         lat_ff       <= 1'b0;
         blank_ff     <= 1'b1;
         addr_ff      <= '0;
         done_ff      <= 1'b0;
         rgb_ff       <= '0;
         rgb_sel_ff   <= 1'b0;
         rd_front_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff   <= phase_in;
            wait_ff    <= wait_in;
            col_ff     <= col_in;
            row_ff     <= row_in;
            frames_ff  <= frames_in;
            front_ff   <= front_in;
            swap_ff    <= swap_in;
            clk_ff     <= clk_in;
            lat_ff     <= lat_in;
            blank_ff   <= blank_in;
            addr_ff    <= addr_in;
            done_ff    <= done_in;
            rgb_ff     <= rgb_shown;
            rgb_sel_ff <= rd_en;
            if (rd_en) begin
               rd_front_ff <= front_in;
            end
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // clearing pass over both stores after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // writes go to the back store
   assign shifted_word = req_if.gpio_word >> data_shift_ff;
   assign wr_pixel     = shifted_word[PIX_W-1:0];

   always_comb begin
      wr_a = '0;
      wr_b = '0;
      if (clearing_ff) begin
         wr_a.en   = 1'b1;
         wr_a.addr = clr_addr_ff;
         wr_b.en   = 1'b1;
         wr_b.addr = clr_addr_ff;
      end else begin
         wr_a.en   = req_fire && (req_if.func == FUNC_WRITE) && front_ff;
         wr_a.addr = req_if.pixel_index;
         wr_a.data = wr_pixel;
         wr_b.en   = req_fire && (req_if.func == FUNC_WRITE) && !front_ff;
         wr_b.addr = req_if.pixel_index;
         wr_b.data = wr_pixel;
      end
   end

   lmrs_frame_store u_store_a (
      .clock   (clock),
      .wr      (wr_a),
      .rd_en   (rd_en && req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data_a)
   );

   lmrs_frame_store u_store_b (
      .clock   (clock),
      .wr      (wr_b),
      .rd_en   (rd_en && req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data_b)
   );

   // rgb holds unless the last item fetched a new pixel
   assign rgb_shown = rgb_sel_ff ? (rd_front_ff ? rd_data_b : rd_data_a) : rgb_ff;

   // result
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.rgb         = rgb_shown;
   assign rsp_if.shift_clock = clk_ff;
   assign rsp_if.latch       = lat_ff;
   assign rsp_if.blank       = blank_ff;
   assign rsp_if.row_address = addr_ff;
   assign rsp_if.busy_res    = (phase_ff != PH_IDLE);
   assign rsp_if.frame_done  = done_ff;

   // a frame end always leaves the panel dark
   a_done_dark: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> blank_ff && !lat_ff && !clk_ff)
      else $error("frame end with panel lit or strobes high");

   // an idle scanner keeps clock and latch low
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> !clk_ff && !lat_ff)
      else $error("strobe high while idle");

   // a fresh pixel is only shown in the clock-low phase
   a_pixel_phase: assert property (@(posedge clock) disable iff (reset)
      rgb_sel_ff |-> (phase_ff == PH_LOW) && !clk_ff)
      else $error("pixel fetched outside clock-low phase");

   // a running phase always has time left
   a_wait_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (wait_ff != '0))
      else $error("active phase with zero wait");

   // frame_done only rises on an accepted tick
   a_done_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(req_fire) && ($past(req_if.func) == FUNC_TICK))
      else $error("frame end without a tick");

endmodule

[sim/led_matrix_row_scanner_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the LED matrix row scanner: watches the request, result and
// register channels, predicts the pin levels each item leaves behind and compares.
// Depends on lmrs_pkg and the lmrs_req_if, lmrs_rsp_if and lmrs_csr_if interfaces.
module led_matrix_row_scanner_checker import lmrs_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int FLUSH_TICKS = DEF_FLUSH_TICKS
) (
   input  logic clock,
   input  logic reset,
   lmrs_req_if  req,
   lmrs_rsp_if  rsp,
   lmrs_csr_if  csr,
   output int   fail_count,
   output int   pending_count,
   output int   items_seen,
   output int   frames_scanned
);

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_SETUP, SCAN_LOW, SCAN_HIGH,
      SCAN_FLUSH, SCAN_LATCH, SCAN_ON, SCAN_ROWEND
   } scan_phase_type;

   typedef struct packed {
      logic [PIX_W-1:0] rgb;
      logic             shift_clock;
      logic             latch;
      logic             blank;
      logic [ROW_W-1:0] row_address;
      logic             busy;
      logic             frame_done;
   } panel_pins_type;

   // Register copies
   logic [7:0]  cfg_columns;
   logic [5:0]  cfg_rows;
   logic [2:0]  cfg_row_bits;
   logic [4:0]  cfg_shift;
   logic [19:0] cfg_on;
   logic [7:0]  cfg_setup;
   logic [7:0]  cfg_half;
   logic [7:0]  cfg_latch;

   // Panel state
   logic [PIX_W-1:0] store_a [STORE_DEPTH];
   logic [PIX_W-1:0] store_b [STORE_DEPTH];
   logic             front_b;
   logic             swap_pend;
   scan_phase_type   scan_ph;
   logic [4:0]       row_n;
   logic [6:0]       col_n;
   logic [WAIT_W-1:0] wait_n;
   logic [15:0]      frames_left;
   logic [PIX_W-1:0] pin_rgb;
   logic             pin_clk;
   logic             pin_lat;
   logic             pin_blank;
   logic [ROW_W-1:0] pin_addr;
   logic             done_pulse;

   panel_pins_type   expected_pins [$];

   function automatic void clear_panel_model();
      cfg_columns  = RST_COLUMNS;
      cfg_rows     = RST_ROWS_SCANNED;
      cfg_row_bits = RST_ROW_BITS;
      cfg_shift    = RST_DATA_SHIFT;
      cfg_on       = RST_ON_TICKS;
      cfg_setup    = RST_SETUP_TICKS;
      cfg_half     = RST_HALF_PERIOD;
      cfg_latch    = RST_LATCH_TICKS;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_a[i] = '0;
         store_b[i] = '0;
      end
      front_b     = 1'b0;
      swap_pend   = 1'b0;
      scan_ph     = SCAN_IDLE;
      row_n       = '0;
      col_n       = '0;
      wait_n      = '0;
      frames_left = '0;
      pin_rgb     = '0;
      pin_clk     = 1'b0;
      pin_lat     = 1'b0;
      pin_blank   = 1'b1;
      pin_addr    = '0;
      done_pulse  = 1'b0;
   endfunction

   function automatic void load_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_COLUMNS:      cfg_columns  = value[7:0];
         CSR_ROWS_SCANNED: cfg_rows     = value[5:0];
         CSR_ROW_BITS:     cfg_row_bits = value[2:0];
         CSR_DATA_SHIFT:   cfg_shift    = value[4:0];
         CSR_ON_TICKS:     cfg_on       = value[19:0];
         CSR_SETUP_TICKS:  cfg_setup    = value[7:0];
         CSR_HALF_PERIOD:  cfg_half     = value[7:0];
         CSR_LATCH_TICKS:  cfg_latch    = value[7:0];
         default: ;
      endcase
   endfunction

   // Saturated counts as the scan sees them
   function automatic int active_columns();
      int c = cfg_columns;
      if (c < 1) c = 1;
      if (c > MAX_COLUMNS) c = MAX_COLUMNS;
      return c;
   endfunction

   function automatic int active_rows();
      int r = cfg_rows;
      if (r < 1) r = 1;
      if (r > MAX_ROWS) r = MAX_ROWS;
      return r;
   endfunction

   function automatic logic [WAIT_W-1:0] clock_phase_ticks();
      return (cfg_half == 0) ? WAIT_W'(1) : WAIT_W'(cfg_half);
   endfunction

   // Enter a phase; zero-length phases fall through within the same tick
   function automatic void enter_phase(scan_phase_type first);
      scan_phase_type p;
      int rb;
      int idx;
      p = first;
      while (1'b1) begin
         case (p)
            SCAN_SETUP: begin
               rb = cfg_row_bits;
               if (rb < 1) rb = 1;
               if (rb > ROW_BITS_MAX) rb = ROW_BITS_MAX;
               pin_blank = 1'b1;
               pin_lat   = 1'b0;
               pin_clk   = 1'b0;
               pin_addr  = ROW_W'(row_n & ((1 << rb) - 1));
               if (cfg_setup == 0) p = SCAN_LOW;
               else begin
                  wait_n  = WAIT_W'(cfg_setup);
                  scan_ph = SCAN_SETUP;
                  return;
               end
            end
            SCAN_LOW: begin
               idx     = (row_n * active_columns() + col_n) % STORE_DEPTH;
               pin_rgb = front_b ? store_b[idx] : store_a[idx];
               pin_clk = 1'b0;
               wait_n  = clock_phase_ticks();
               scan_ph = SCAN_LOW;
               return;
            end
            SCAN_HIGH: begin
               pin_clk = 1'b1;
               wait_n  = clock_phase_ticks();
               scan_ph = SCAN_HIGH;
               return;
            end
            SCAN_FLUSH: begin
               pin_clk = 1'b0;
               if (FLUSH_TICKS == 0) p = SCAN_LATCH;
               else begin
                  wait_n  = WAIT_W'(FLUSH_TICKS);
                  scan_ph = SCAN_FLUSH;
                  return;
               end
            end
            SCAN_LATCH: begin
               pin_lat = 1'b1;
               if (cfg_latch == 0) p = SCAN_ON;
               else begin
                  wait_n  = WAIT_W'(cfg_latch);
                  scan_ph = SCAN_LATCH;
                  return;
               end
            end
            SCAN_ON: begin
               pin_lat   = 1'b0;
               pin_blank = 1'b0;
               if (cfg_on == 0) p = SCAN_ROWEND;
               else begin
                  wait_n  = cfg_on;
                  scan_ph = SCAN_ON;
                  return;
               end
            end
            default: begin
               // end of row; after the last row the frame closes
               col_n = '0;
               if (row_n + 1 >= active_rows()) begin
                  pin_blank  = 1'b1;
                  pin_lat    = 1'b0;
                  pin_clk    = 1'b0;
                  done_pulse = 1'b1;
                  if (frames_left > 0) frames_left--;
                  if (swap_pend) begin
                     front_b   = ~front_b;
                     swap_pend = 1'b0;
                  end
                  row_n = '0;
                  if (frames_left == 0) begin
                     scan_ph = SCAN_IDLE;
                     wait_n  = '0;
                     return;
                  end
               end else begin
                  row_n++;
               end
               p = SCAN_SETUP;
            end
         endcase
      end
   endfunction

   function automatic void tick_panel();
      scan_phase_type nx;
      if (scan_ph == SCAN_IDLE) return;
      if (wait_n > 0) wait_n--;
      if (wait_n != 0) return;
      case (scan_ph)
         SCAN_SETUP: nx = SCAN_LOW;
         SCAN_LOW:   nx = SCAN_HIGH;
         SCAN_HIGH: begin
            if (col_n + 1 >= active_columns()) nx = SCAN_FLUSH;
            else begin
               col_n++;
               nx = SCAN_LOW;
            end
         end
         SCAN_FLUSH: nx = SCAN_LATCH;
         SCAN_LATCH: nx = SCAN_ON;
         default:    nx = SCAN_ROWEND;
      endcase
      enter_phase(nx);
   endfunction

   // Apply one item and return the pins it leaves
   function automatic panel_pins_type advance_panel(func_type f, logic [11:0] idx,
                                                    logic [31:0] word, logic [15:0] cnt);
      panel_pins_type r;
      logic [31:0] shifted;
      done_pulse = 1'b0;
      case (f)
         FUNC_TICK: tick_panel();
         FUNC_WRITE: begin
            shifted = word >> cfg_shift;
            if (front_b) store_a[idx] = shifted[PIX_W-1:0];
            else store_b[idx] = shifted[PIX_W-1:0];
         end
         FUNC_SWAP: begin
            if (scan_ph != SCAN_IDLE) swap_pend = ~swap_pend;
            else front_b = ~front_b;
         end
         FUNC_START: begin
            if (scan_ph == SCAN_IDLE && cnt != 0) begin
               frames_left = cnt;
               row_n       = '0;
               col_n       = '0;
               enter_phase(SCAN_SETUP);
            end
         end
         default: ;
      endcase
      r.rgb         = pin_rgb;
      r.shift_clock = pin_clk;
      r.latch       = pin_lat;
      r.blank       = pin_blank;
      r.row_address = pin_addr;
      r.busy        = (scan_ph != SCAN_IDLE);
      r.frame_done  = done_pulse;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Track every handshake at the rising edge
   always @(posedge clock) begin
      panel_pins_type want;
      if (reset) begin
         clear_panel_model();
         expected_pins.delete();
      end else begin
         if (csr.valid && csr.ready) load_register(csr.index, csr.data);
         if (req.valid && req.ready) begin
            expected_pins.push_back(advance_panel(req.func, req.pixel_index,
                                                  req.gpio_word, req.frame_count));
            items_seen++;
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_pins.size() == 0) begin
               $error("result item with no request item outstanding");
               fail_count++;
            end else begin
               want = expected_pins.pop_front();
               check_field("rgb", want.rgb, rsp.rgb);
               check_field("shift_clock", want.shift_clock, rsp.shift_clock);
               check_field("latch", want.latch, rsp.latch);
               check_field("blank", want.blank, rsp.blank);
               check_field("row_address", want.row_address, rsp.row_address);
               check_field("busy_res", want.busy, rsp.busy_res);
               check_field("frame_done", want.frame_done, rsp.frame_done);
               if (want.frame_done) frames_scanned++;
            end
         end
      end
      pending_count = expected_pins.size();
   end

endmodule

[sim/led_matrix_row_scanner_tb.sv]
`timescale 1ns / 100ps
// Top of the LED matrix row scanner testbench: clock, reset, stimulus and verdict.
// Depends on lmrs_pkg, the channel interfaces, the scanner and its checker.
module led_matrix_row_scanner_tb;
   import lmrs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_ready_q = 1'b0;
   int   sender_pct = 0;
   int   receiver_pct = 0;
   int   area = 1;
   int   cycle_count = 0;
   int   fail_count;
   int   pending_count;
   int   items_seen;
   int   frames_scanned;

   lmrs_req_if req_if();
   lmrs_rsp_if rsp_if();
   lmrs_csr_if csr_if();

   led_matrix_row_scanner dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   led_matrix_row_scanner_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr            (csr_if),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .items_seen     (items_seen),
      .frames_scanned (frames_scanned)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side stalls at random
   always @(negedge clock) begin
      rsp_ready_q <= ($urandom_range(0, 99) >= receiver_pct);
   end
   assign rsp_if.ready = rsp_ready_q;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // One item; entered and left at a falling edge, valid left high
   task automatic send_item(input func_type f, input logic [11:0] idx,
                            input logic [31:0] word, input logic [15:0] cnt);
      while ($urandom_range(0, 99) < sender_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.func        <= f;
      req_if.pixel_index <= idx;
      req_if.gpio_word   <= word;
      req_if.frame_count <= cnt;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [19:0] cols, input logic [19:0] rows,
                             input logic [19:0] rbits, input logic [19:0] shift,
                             input logic [19:0] on, input logic [19:0] setup,
                             input logic [19:0] half, input logic [19:0] latch);
      int c;
      int r;
      write_reg(CSR_COLUMNS, cols);
      write_reg(CSR_ROWS_SCANNED, rows);
      write_reg(CSR_ROW_BITS, rbits);
      write_reg(CSR_DATA_SHIFT, shift);
      write_reg(CSR_ON_TICKS, on);
      write_reg(CSR_SETUP_TICKS, setup);
      write_reg(CSR_HALF_PERIOD, half);
      write_reg(CSR_LATCH_TICKS, latch);
      csr_if.valid <= 1'b0;
      // pixel range the scan actually reads, for targeted writes
      c = int'(cols[7:0]);
      r = int'(rows[5:0]);
      if (c < 1) c = 1;
      if (c > DEF_MAX_COLUMNS) c = DEF_MAX_COLUMNS;
      if (r < 1) r = 1;
      if (r > DEF_MAX_ROWS) r = DEF_MAX_ROWS;
      area = (c * r > STORE_DEPTH) ? STORE_DEPTH : c * r;
   endtask

   // Drop valid and wait until every result is back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int pick;
      logic [11:0] idx;
      logic [15:0] cnt;

      req_if.valid       = 1'b0;
      req_if.func        = FUNC_TICK;
      req_if.pixel_index = '0;
      req_if.gpio_word   = '0;
      req_if.frame_count = '0;
      csr_if.valid       = 1'b0;
      csr_if.index       = CSR_COLUMNS;
      csr_if.data        = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < 12; ph++) begin
         // idling pattern rotates: none, sender, receiver, both
         case (ph % 4)
            0: begin sender_pct = 0;  receiver_pct = 0;  end
            1: begin sender_pct = 75; receiver_pct = 0;  end
            2: begin sender_pct = 0;  receiver_pct = 75; end
            default: begin sender_pct = 31; receiver_pct = 31; end
         endcase
         case (ph)
            0: set_config(3, 2, 1, 5, 2, 1, 1, 1);
            1: set_config(2, 3, 2, 0, 1, 0, 0, 0);          // zero-length phases
            2: set_config(0, 0, 0, 31, 0, 2, 1, 0);         // counts below range
            3: set_config(4, 63, 7, 26, 0, 0, 0, 0);        // counts above range
            4: set_config(255, 1, 3, 13, 3, 1, 0, 2);       // widest row
            5: set_config(1, 2, 5, 7, 4, 255, 1, 255);      // longest setup and latch
            6: set_config(1, 1, 1, 20, 2, 0, 255, 0);       // slowest shift clock
            7: set_config(2, 4, 2, 3, 5, 3, 2, 3);
            default: set_config(20'($urandom_range(1, 5)), 20'($urandom_range(1, 5)),
                                20'($urandom_range(0, 7)), 20'($urandom_range(0, 31)),
                                20'($urandom_range(0, 6)), 20'($urandom_range(0, 4)),
                                20'($urandom_range(0, 3)), 20'($urandom_range(0, 4)));
         endcase

         if (ph == 0) begin
            // directed: field extremes, every operation, start and swap corner cases
            send_item(FUNC_START, 12'd0, 32'd0, 16'd0);               // zero count ignored
            send_item(FUNC_WRITE, 12'd0, 32'hFFFF_FFFF, 16'hFFFF);
            send_item(FUNC_WRITE, 12'hFFF, 32'h0, 16'd0);
            send_item(FUNC_WRITE, 12'd1, 32'h0000_0A60, 16'd0);
            send_item(FUNC_WRITE, 12'd4, $urandom, 16'd0);
            send_item(FUNC_SWAP, 12'd0, 32'd0, 16'd0);                // idle swap is immediate
            send_item(FUNC_WRITE, 12'd2, $urandom, 16'd0);
            send_item(FUNC_START, 12'd0, 32'd0, 16'd2);
            send_item(FUNC_START, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF);  // busy, ignored
            send_item(FUNC_SWAP, 12'd0, 32'd0, 16'd0);                // two swaps cancel
            send_item(FUNC_SWAP, 12'd0, 32'd0, 16'd0);
            send_item(FUNC_SWAP, 12'd0, 32'd0, 16'd0);                // held to frame end
            repeat (10) send_item(FUNC_TICK, 12'($urandom), $urandom, 16'($urandom));
            send_item(FUNC_WRITE, 12'd3, $urandom, 16'd0);
         end

         repeat (150) begin
            pick = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, area - 1))
                                               : 12'($urandom);
            if ($urandom_range(0, 24) == 0) cnt = 16'($urandom);
            else if ($urandom_range(0, 9) == 0) cnt = 16'd0;
            else cnt = 16'($urandom_range(1, 3));
            if (pick < 68) send_item(FUNC_TICK, 12'($urandom), $urandom, 16'($urandom));
            else if (pick < 85) send_item(FUNC_WRITE, idx, $urandom, 16'($urandom));
            else if (pick < 90) send_item(FUNC_SWAP, 12'($urandom), $urandom, 16'($urandom));
            else send_item(FUNC_START, 12'($urandom), $urandom, cnt);
         end
         drain();
      end

      // longest lit time last: the scan parks there until the run ends
      sender_pct   = 31;
      receiver_pct = 31;
      set_config(2, 2, 1, 0, 20'hFFFFF, 1, 0, 1);
      send_item(FUNC_START, 12'd0, 32'd0, 16'd1);
      repeat (60) send_item(FUNC_TICK, 12'($urandom), $urandom, 16'($urandom));
      send_item(FUNC_WRITE, 12'($urandom_range(0, 3)), $urandom, 16'd0);
      drain();
      repeat (16) @(negedge clock);

      $display("Ran %0d items through 13 register settings and all idling patterns;",
               items_seen);
      $display("%0d frame ends were seen on the result channel.", frames_scanned);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
